// ===== src/hpf_pkg.sv =====
// Shared widths, payload types and register codes of the harmonic pair force block.
`default_nettype none

package hpf_pkg;

  // Coordinates are the low COORD_WIDTH bits of each 32-bit field.
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned EXT_W       = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int unsigned DW          = COORD_WIDTH + 1;           // difference and its magnitude
  localparam int unsigned SW          = 2 * DW;                    // sum of squares
  localparam int unsigned RW          = COORD_WIDTH + 1;           // distance R
  localparam int unsigned GW          = (RW > FIELD_W) ? RW : FIELD_W;  // |R0 - R|
  localparam int unsigned KW          = FIELD_W + GW;              // k * |R0 - R|
  localparam int unsigned NW          = FIELD_W + 2 * GW;          // full products
  localparam int unsigned FRAC        = 16;
  localparam int unsigned QW          = FIELD_W + FRAC;            // quotient bits kept
  localparam int unsigned E_SHIFT     = 33;                        // 0.5 and the Q.48 to Q.16 step

  typedef enum logic [0:0] {
    CFG_SPRING = 1'b0,
    CFG_REST   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
  } in_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] energy;
    logic signed [FIELD_W-1:0] force_x;
    logic signed [FIELD_W-1:0] force_y;
    logic signed [FIELD_W-1:0] force_z;
    logic                      zero_distance;
    logic                      overflow;
  } out_t;

  // Distance and difference vector leaving the square root pipeline.
  typedef struct packed {
    logic [RW-1:0]         root;
    logic [2:0][DW-1:0]    dmag;
    logic [2:0]            dneg;
  } sq_t;

  // Per-transaction side information that rides along the divider.
  typedef struct packed {
    logic [FIELD_W-1:0] energy;
    logic               eovf;
    logic               zero;
    logic [2:0]         neg;
    logic [2:0]         big;
  } side_t;

endpackage

`default_nettype wire

// ===== src/harmonic_pair_force_top.sv =====
// Top level of the harmonic pair force block: registers, pipeline and output stage.
//
//   port group   direction  handshake               payload
//   in           input      in_valid_i / in_stall_o  hpf_pkg::in_t
//   out          output     out_valid_o / out_stall_i hpf_pkg::out_t
//   cfg          input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One transaction enters per cycle while in_stall_o is low; the pipeline is built from
// the one-bit-per-stage square root, the spring multipliers and the 48-stage force divider.
// Reset clears the valid bits and loads k = 1.0 and R0 = 0.
// The whole pipeline holds while a result waits in the output register under stall and
// the last stage is full; bubbles before that point are held as well.
`default_nettype none

module harmonic_pair_force_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hpf_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hpf_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  hpf_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [hpf_pkg::FIELD_W-1:0]  cfg_data_i
);
  import hpf_pkg::*;

  logic [FIELD_W-1:0] k_q, r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= FIELD_W'(65536);
      r0_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPRING: k_q  <= cfg_data_i;
        CFG_REST:   r0_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic               en;
  logic               sq_vld, mul_vld, div_vld;
  sq_t                sq;
  side_t              mul_side, div_side;
  logic [RW-1:0]      mul_root;
  logic [2:0][RW-1:0] mul_rem;
  logic [2:0][QW-1:0] mul_dvd, quo;
  logic               out_valid_q;
  out_t               out_data_q;

  assign en         = !(div_vld && out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  hpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (sq_vld),
    .sq_o    (sq)
  );

  hpf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .sq_i    (sq),
    .k_i     (k_q),
    .r0_i    (r0_q),
    .valid_o (mul_vld),
    .side_o  (mul_side),
    .root_o  (mul_root),
    .rem_o   (mul_rem),
    .dvd_o   (mul_dvd)
  );

  hpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mul_vld),
    .side_i  (mul_side),
    .root_i  (mul_root),
    .rem_i   (mul_rem),
    .dvd_i   (mul_dvd),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (quo)
  );

  // Saturation, sign and the coincident-position case.
  logic [2:0][FIELD_W-1:0] frc;
  logic                    fsat;
  out_t                    res;

  always_comb begin
    logic [FIELD_W-1:0] q, lim, m;
    logic               sat;
    fsat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      q      = quo[l][QW-1:FRAC];
      lim    = div_side.neg[l] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
      sat    = div_side.big[l] || (q > lim);
      m      = sat ? lim : q;
      frc[l] = div_side.zero ? '0 : (div_side.neg[l] ? FIELD_W'(-m) : m);
      fsat   = fsat | (sat & !div_side.zero);
    end
    res.energy        = div_side.energy;
    res.force_x       = frc[0];
    res.force_y       = frc[1];
    res.force_z       = frc[2];
    res.zero_distance = div_side.zero;
    res.overflow      = div_side.eovf | fsat;
  end

  logic out_valid_d;

  always_comb begin
    priority if (en && div_vld) out_valid_d = 1'b1;
    else if (!out_stall_i)      out_valid_d = 1'b0;
    else                        out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (en && div_vld) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && div_vld))
    else $error("input stalled without a blocked result at the output");

  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_distance) |->
      (out_data_o.force_x == '0 && out_data_o.force_y == '0 && out_data_o.force_z == '0))
    else $error("nonzero force reported for coincident positions");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while the pipeline was held");

endmodule

`default_nettype wire

// ===== src/hpf_sqrt.sv =====
// Difference vector, sum of squares and a one-bit-per-stage square root pipeline.
`default_nettype none

module hpf_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  hpf_pkg::in_t  data_i,
  output logic          valid_o,
  output hpf_pkg::sq_t  sq_o
);
  import hpf_pkg::*;

  localparam int unsigned TW = SW + 2;

  function automatic logic [DW-1:0] coord(input logic [FIELD_W-1:0] raw);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(raw);
    return DW'($signed(ext[COORD_WIDTH-1:0]));
  endfunction

  logic [2:0][DW-1:0] pa, pb, mag_d;
  logic [2:0]         neg_d;

  always_comb begin
    logic signed [DW-1:0] diff;
    pa[0] = coord(data_i.first_x);
    pa[1] = coord(data_i.first_y);
    pa[2] = coord(data_i.first_z);
    pb[0] = coord(data_i.second_x);
    pb[1] = coord(data_i.second_y);
    pb[2] = coord(data_i.second_z);
    for (int i = 0; i < 3; i++) begin
      diff     = $signed(pa[i]) - $signed(pb[i]);
      neg_d[i] = diff[DW-1];
      mag_d[i] = diff[DW-1] ? DW'(-diff) : DW'(diff);
    end
  end

  logic               va_q, vb_q;
  logic [2:0][DW-1:0] mag_a_q, mag_b_q;
  logic [2:0]         neg_a_q, neg_b_q;
  logic [2:0][SW-1:0] sqr_q;

  logic                vld_q  [RW+1];
  logic [SW-1:0]       rem_q  [RW+1];
  logic [RW-1:0]       root_q [RW+1];
  logic [2:0][DW-1:0]  mag_q  [RW+1];
  logic [2:0]          neg_q  [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      for (int k = 0; k <= RW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      va_q     <= valid_i;
      vb_q     <= va_q;
      vld_q[0] <= vb_q;
      for (int k = 0; k < RW; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_d;
      neg_a_q <= neg_d;
      for (int i = 0; i < 3; i++) sqr_q[i] <= SW'(mag_a_q[i]) * SW'(mag_a_q[i]);
      mag_b_q <= mag_a_q;
      neg_b_q <= neg_a_q;
      rem_q[0]  <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      root_q[0] <= '0;
      mag_q[0]  <= mag_b_q;
      neg_q[0]  <= neg_b_q;
    end
  end

  // Restoring square root: the remainder always holds S - root^2.
  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam int unsigned B = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          take;

    assign trial = (TW'(root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = (TW'(rem_q[k]) >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? (rem_q[k] - trial[SW-1:0]) : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (RW'(1) << B)) : root_q[k];
        mag_q[k+1]  <= mag_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end
  end

  assign valid_o   = vld_q[RW];
  assign sq_o.root = root_q[RW];
  assign sq_o.dmag = mag_q[RW];
  assign sq_o.dneg = neg_q[RW];

endmodule

`default_nettype wire

// ===== src/hpf_mul.sv =====
// Spring products: k*|R0-R| times the gap and the difference, energy and divider setup.
`default_nettype none

module hpf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  hpf_pkg::sq_t                  sq_i,
  input  logic [hpf_pkg::FIELD_W-1:0]   k_i,
  input  logic [hpf_pkg::FIELD_W-1:0]   r0_i,
  output logic                          valid_o,
  output hpf_pkg::side_t                side_o,
  output logic [hpf_pkg::RW-1:0]        root_o,
  output logic [2:0][hpf_pkg::RW-1:0]   rem_o,
  output logic [2:0][hpf_pkg::QW-1:0]   dvd_o
);
  import hpf_pkg::*;

  localparam int unsigned LW = FIELD_W + GW;
  localparam int unsigned HW = 2 * GW;

  logic [GW:0]   gap;
  logic          gneg_d;
  logic [GW-1:0] ae_d;

  assign gap    = (GW+1)'(r0_i) - (GW+1)'(sq_i.root);
  assign gneg_d = gap[GW];
  assign ae_d   = gneg_d ? GW'(-gap) : GW'(gap);

  logic [3:0]          v_q;
  logic [GW-1:0]       ae0_q, ae1_q;
  logic [KW-1:0]       ka1_q;
  logic [3:0][LW-1:0]  lo2_q;
  logic [3:0][HW-1:0]  hi2_q;
  logic [3:0][NW-1:0]  n3_q;
  logic [RW-1:0]       root0_q, root1_q, root2_q, root3_q;
  logic [2:0][DW-1:0]  mag0_q, mag1_q;
  logic [2:0]          dneg0_q, dneg1_q, dneg2_q, dneg3_q;
  logic                gneg0_q, gneg1_q, gneg2_q, gneg3_q;
  logic                out_v_q;

  logic [3:0][GW-1:0] ops;

  always_comb begin
    ops[0] = ae1_q;
    for (int i = 0; i < 3; i++) ops[i+1] = GW'(mag1_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[2:0], valid_i};
      out_v_q <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ae0_q   <= ae_d;
      gneg0_q <= gneg_d;
      root0_q <= sq_i.root;
      mag0_q  <= sq_i.dmag;
      dneg0_q <= sq_i.dneg;

      ka1_q   <= KW'(k_i) * KW'(ae0_q);
      ae1_q   <= ae0_q;
      gneg1_q <= gneg0_q;
      root1_q <= root0_q;
      mag1_q  <= mag0_q;
      dneg1_q <= dneg0_q;

      // Each wide product is split at bit 32 of k*|R0-R|.
      for (int j = 0; j < 4; j++) begin
        lo2_q[j] <= LW'(ka1_q[FIELD_W-1:0]) * LW'(ops[j]);
        hi2_q[j] <= HW'(ka1_q[KW-1:FIELD_W]) * HW'(ops[j]);
      end
      gneg2_q <= gneg1_q;
      root2_q <= root1_q;
      dneg2_q <= dneg1_q;

      for (int j = 0; j < 4; j++) n3_q[j] <= (NW'(hi2_q[j]) << FIELD_W) + NW'(lo2_q[j]);
      gneg3_q <= gneg2_q;
      root3_q <= root2_q;
      dneg3_q <= dneg2_q;
    end
  end

  side_t                side_d;
  logic [2:0][RW-1:0]   rem_d;
  logic [2:0][QW-1:0]   dvd_d;

  always_comb begin
    side_d.eovf   = |n3_q[0][NW-1:E_SHIFT+FIELD_W];
    side_d.energy = side_d.eovf ? '1 : n3_q[0][E_SHIFT+FIELD_W-1:E_SHIFT];
    side_d.zero   = (root3_q == '0);
    for (int i = 0; i < 3; i++) begin
      side_d.neg[i] = gneg3_q ^ dneg3_q[i];
      // A quotient of 2^QW or more saturates whatever its low bits are.
      side_d.big[i] = (n3_q[i+1] >= (NW'(root3_q) << QW));
      rem_d[i]      = RW'(n3_q[i+1] >> QW);
      dvd_d[i]      = n3_q[i+1][QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_d;
      root_o <= root3_q;
      rem_o  <= rem_d;
      dvd_o  <= dvd_d;
    end
  end

  assign valid_o = out_v_q;

endmodule

`default_nettype wire

// ===== src/hpf_div.sv =====
// Three-lane restoring divider, one quotient bit per stage, with side information alongside.
`default_nettype none

module hpf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  hpf_pkg::side_t                side_i,
  input  logic [hpf_pkg::RW-1:0]        root_i,
  input  logic [2:0][hpf_pkg::RW-1:0]   rem_i,
  input  logic [2:0][hpf_pkg::QW-1:0]   dvd_i,
  output logic                          valid_o,
  output hpf_pkg::side_t                side_o,
  output logic [2:0][hpf_pkg::QW-1:0]   quo_o
);
  import hpf_pkg::*;

  logic                vld_q  [QW+1];
  side_t               side_q [QW+1];
  logic [RW-1:0]       root_q [QW+1];
  logic [2:0][RW-1:0]  rem_q  [QW+1];
  // Dividend bits leave at the top while quotient bits enter at the bottom.
  logic [2:0][QW-1:0]  sh_q   [QW+1];

  assign vld_q[0]  = valid_i;
  assign side_q[0] = side_i;
  assign root_q[0] = root_i;
  assign rem_q[0]  = rem_i;
  assign sh_q[0]   = dvd_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [2:0][RW:0] r2;
    logic [2:0]       ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        r2[l] = {rem_q[k][l], sh_q[k][l][QW-1]};
        ge[l] = (r2[l] >= {1'b0, root_q[k]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[k+1][l] <= ge[l] ? RW'(r2[l] - {1'b0, root_q[k]}) : RW'(r2[l]);
          sh_q[k+1][l]  <= {sh_q[k][l][QW-2:0], ge[l]};
        end
        side_q[k+1] <= side_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign quo_o   = sh_q[QW];

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the harmonic pair force block with a local fixed-point model.
`timescale 1ns / 100ps

module testbench;
  import hpf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  cfg_idx_e    cfg_idx_i = CFG_SPRING;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] spring_k;
  logic [31:0] rest_len;
  out_t        expected_forces[$];
  int          error_count = 0;
  bit          sender_busy_mode = 1'b0;
  bit          receiver_busy_mode = 1'b0;
  bit          hold_long = 1'b0;

  harmonic_pair_force_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [127:0] abs_wide(logic signed [63:0] v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Exact wide-integer evaluation of energy and force for one position pair.
  function automatic out_t predict_force(in_t p);
    logic signed [63:0] diff[3];
    logic [127:0]       sum_sq, cand, radius, gap_mag, e, n, q, lim;
    logic signed [63:0] gap;
    bit                 neg, ovf;
    out_t               o;
    diff[0] = longint'(p.first_x) - longint'(p.second_x);
    diff[1] = longint'(p.first_y) - longint'(p.second_y);
    diff[2] = longint'(p.first_z) - longint'(p.second_z);
    sum_sq = '0;
    for (int i = 0; i < 3; i++) sum_sq += abs_wide(diff[i]) * abs_wide(diff[i]);
    radius = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = radius | (128'(1) << b);
      if (cand * cand <= sum_sq) radius = cand;
    end
    gap = longint'(rest_len) - longint'(radius[63:0]);
    gap_mag = abs_wide(gap);
    ovf = 1'b0;
    e = (gap_mag * gap_mag * 128'(spring_k)) >> 33;
    if (e > 128'hFFFF_FFFF) begin
      o.energy = 32'hFFFF_FFFF;
      ovf = 1'b1;
    end else begin
      o.energy = e[31:0];
    end
    for (int i = 0; i < 3; i++) begin
      q = '0;
      if (radius != 0) begin
        neg = (gap < 0) != (diff[i] < 0);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        n = 128'(spring_k) * gap_mag * abs_wide(diff[i]);
        q = (n / radius) >> 16;
        if (q > lim) begin
          q = lim;
          ovf = 1'b1;
        end
        if (neg) q = -q;
      end
      case (i)
        0: o.force_x = q[31:0];
        1: o.force_y = q[31:0];
        default: o.force_z = q[31:0];
      endcase
    end
    o.zero_distance = (radius == 0);
    o.overflow = ovf;
    return o;
  endfunction

  task automatic send_pair(in_t item);
    int gap_cycles;
    gap_cycles = sender_busy_mode ? 0 : $urandom_range(0, 4);
    if (gap_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_forces.push_back(predict_force(item));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SPRING) spring_k = value;
    else rest_len = value;
  endtask

  task automatic set_params(logic [31:0] k, logic [31:0] r0);
    drain();
    write_reg(CFG_SPRING, k);
    write_reg(CFG_REST, r0);
  endtask

  function automatic in_t pair_at(int ax, int ay, int az, int bx, int by, int bz);
    in_t p;
    p.first_x = ax;  p.first_y = ay;  p.first_z = az;
    p.second_x = bx; p.second_y = by; p.second_z = bz;
    return p;
  endfunction

  // Mostly nearby pairs so forces stay in range, with some fully random ones.
  function automatic in_t random_pair();
    in_t p;
    int  span;
    p = pair_at($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 3) != 0) begin
      span = 1 << $urandom_range(0, 24);
      p.second_x = p.first_x + $urandom_range(0, 2 * span) - span;
      p.second_y = p.first_y + $urandom_range(0, 2 * span) - span;
      p.second_z = p.first_z + $urandom_range(0, 2 * span) - span;
    end
    if ($urandom_range(0, 30) == 0) p.second_x = p.first_x;
    if ($urandom_range(0, 40) == 0) p = pair_at(p.first_x, p.first_y, p.first_z,
                                                p.first_x, p.first_y, p.first_z);
    return p;
  endfunction

  task automatic test_directed;
    send_pair(pair_at(0, 0, 0, 0, 0, 0));
    send_pair(pair_at(32'h12345, -7, 99, 32'h12345, -7, 99));
    send_pair(pair_at(32'h10000, 0, 0, 0, 0, 0));
    send_pair(pair_at(0, 0, 0, 32'h30000, 32'h40000, 0));
    send_pair(pair_at(1, 0, 0, 0, 0, 0));
    send_pair(pair_at(0, -1, 0, 0, 0, 0));
    send_pair(pair_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000));
    send_pair(pair_at(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000));
    send_pair(pair_at(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
    send_pair(pair_at(32'h100, -32'h200, 32'h300, -32'h100, 32'h200, -32'h300));
  endtask

  task automatic test_config_sweep;
    logic [31:0] ks[5] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h8000, 32'h30000};
    logic [31:0] rs[5] = '{32'hFFFFFFFF, 32'h0, 32'h20000, 32'h1, 32'h7FFFFFFF};
    for (int c = 0; c < 5; c++) begin
      set_params(ks[c], rs[c]);
      test_directed();
      for (int i = 0; i < 20; i++) send_pair(random_pair());
    end
  endtask

  task automatic test_random;
    for (int i = 0; i < 450; i++) begin
      if (i % 90 == 0) begin
        set_params($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000),
                   $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h100000));
        sender_busy_mode = $urandom_range(0, 2) == 0;
        receiver_busy_mode = $urandom_range(0, 2) == 0;
      end
      send_pair(random_pair());
    end
    sender_busy_mode = 1'b0;
    receiver_busy_mode = 1'b0;
  endtask

  task automatic test_backpressure;
    set_params(32'h10000, 32'h18000);
    sender_busy_mode = 1'b1;
    hold_long = 1'b1;
    for (int i = 0; i < 150; i++) send_pair(random_pair());
    sender_busy_mode = 1'b0;
  endtask

  // Receiver: a wait before each transaction, drawn or set by busy and hold_long modes.
  initial begin
    int wait_cycles;
    forever begin
      if (hold_long) wait_cycles = 300;
      else if (receiver_busy_mode) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 4);
      hold_long = 1'b0;
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = expected_forces.pop_front();
        if (out_data_o.energy !== want.energy) begin
          $error("energy: expected %h actual %h", want.energy, out_data_o.energy);
          error_count++;
        end
        if (out_data_o.force_x !== want.force_x) begin
          $error("force_x: expected %h actual %h", want.force_x, out_data_o.force_x);
          error_count++;
        end
        if (out_data_o.force_y !== want.force_y) begin
          $error("force_y: expected %h actual %h", want.force_y, out_data_o.force_y);
          error_count++;
        end
        if (out_data_o.force_z !== want.force_z) begin
          $error("force_z: expected %h actual %h", want.force_z, out_data_o.force_z);
          error_count++;
        end
        if (out_data_o.zero_distance !== want.zero_distance) begin
          $error("zero_distance: expected %b actual %b",
                 want.zero_distance, out_data_o.zero_distance);
          error_count++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $error("overflow: expected %b actual %b", want.overflow, out_data_o.overflow);
          error_count++;
        end
      end
    end
  end

  initial begin
    spring_k = 32'h10000;
    rest_len = 32'h0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
